// File: rtl/ips_pkg.sv
// shared types and constants for the ipv4 packet statistics block
`timescale 1ns / 1ps
package ips_pkg;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned CntW = 32;
  localparam logic [CntW-1:0] CountMax = '1;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;

  localparam logic [15:0] LimitSmallRst = 16'd160;
  localparam logic [15:0] LimitMediumRst = 16'd640;
  localparam logic [15:0] LimitLargeRst = 16'd1280;
  localparam logic [15:0] LimitHugeRst = 16'd5120;

  typedef enum logic [1:0] {
    REG_LIMIT_SMALL  = 2'd0,
    REG_LIMIT_MEDIUM = 2'd1,
    REG_LIMIT_LARGE  = 2'd2,
    REG_LIMIT_HUGE   = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] ProtoIcmp = 8'h01;
  localparam logic [7:0] ProtoIgmp = 8'h02;
  localparam logic [7:0] ProtoIpip = 8'h04;
  localparam logic [7:0] ProtoTcp = 8'h06;
  localparam logic [7:0] ProtoUdp = 8'h11;
  localparam logic [7:0] ProtoIpv6 = 8'h29;
  localparam logic [7:0] ProtoOspf = 8'h59;

  typedef enum logic [2:0] {
    CLS_ICMP = 3'd0, CLS_IGMP = 3'd1, CLS_IPIP = 3'd2, CLS_TCP = 3'd3,
    CLS_UDP = 3'd4, CLS_IPV6 = 3'd5, CLS_OSPF = 3'd6, CLS_OTHER = 3'd7
  } proto_cls_e;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } hdr_t;

  typedef struct packed {
    logic        counted;
    logic [2:0]  protocol_class;
    logic [31:0] protocol_total;
    logic [2:0]  size_class;
    logic [31:0] size_total;
    logic [31:0] source_total;
    logic [31:0] dest_total;
    logic [31:0] pair_total;
    logic [2:0]  full_flags;
  } res_t;

  // table lookup control between the sequencer and a table unit
  typedef struct packed {
    logic start;
    logic pair;
  } scan_ctl_t;

  typedef struct packed {
    logic        done;
    logic        full;
    logic [31:0] total;
  } scan_sts_t;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_READ = 2'd1,
    SCAN_CHECK = 2'd2,
    SCAN_DONE = 2'd3
  } scan_state_e;

  typedef enum logic [1:0] {
    TOP_IDLE = 2'd0,
    TOP_SCAN = 2'd1,
    TOP_OUT  = 2'd2
  } top_state_e;

  function automatic logic [2:0] proto_class(logic [7:0] p);
    logic [2:0] c;
    unique case (p)
      ProtoIcmp: c = CLS_ICMP;
      ProtoIgmp: c = CLS_IGMP;
      ProtoIpip: c = CLS_IPIP;
      ProtoTcp:  c = CLS_TCP;
      ProtoUdp:  c = CLS_UDP;
      ProtoIpv6: c = CLS_IPV6;
      ProtoOspf: c = CLS_OSPF;
      default:   c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction
endpackage

// File: rtl/ips_if.sv
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface ips_hdr_if;
  logic valid;
  logic ready;
  ips_pkg::hdr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ips_res_if;
  logic valid;
  logic ready;
  ips_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ips_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/ips_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module ips_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/ips_table.sv
// address table: linear scan for match or first free entry, then update
`timescale 1ns / 1ps
module ips_table #(
  parameter int unsigned Entries = ips_pkg::TableEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ips_pkg::scan_ctl_t ctl_i,
  input  logic [31:0]       key_a_i,
  input  logic [31:0]       key_b_i,
  output ips_pkg::scan_sts_t sts_o
);
  localparam int unsigned AddrW = $clog2(Entries);
  localparam int unsigned RamW = 32 + 32 + 32;

  ips_pkg::scan_state_e state_q, state_d;
  logic [AddrW:0] idx_q, idx_d;
  // count of occupied entries; entries below it are in use
  logic [AddrW:0] fill_q, fill_d;
  logic [31:0] total_q, total_d;
  logic full_q, full_d;
  logic we;
  logic [RamW-1:0] wdata, rdata;
  logic [31:0] r_a, r_b, r_cnt, new_cnt;
  logic hit;

  assign r_a = rdata[95:64];
  assign r_b = rdata[63:32];
  assign r_cnt = rdata[31:0];
  assign hit = (r_a == key_a_i && r_b == key_b_i) ||
               (ctl_i.pair && r_a == key_b_i && r_b == key_a_i);
  assign new_cnt = ips_pkg::sat_inc(r_cnt);

  ips_ram #(.Width(RamW), .Depth(Entries)) u_ram (
    .clk_i,
    .we_i    (we),
    .addr_i  (idx_q[AddrW-1:0]),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ips_pkg::SCAN_IDLE;
      idx_q <= '0;
      fill_q <= '0;
      total_q <= '0;
      full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      fill_q <= fill_d;
      total_q <= total_d;
      full_q <= full_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    fill_d = fill_q;
    total_d = total_q;
    full_d = full_q;
    we = 1'b0;
    wdata = {key_a_i, key_b_i, 32'd1};
    unique case (state_q)
      ips_pkg::SCAN_IDLE: begin
        if (ctl_i.start) begin
          idx_d = '0;
          state_d = ips_pkg::SCAN_READ;
        end
      end
      ips_pkg::SCAN_READ: begin
        if (idx_q == fill_q) begin
          if (fill_q == (AddrW+1)'(Entries)) begin
            total_d = '0;
            full_d = 1'b1;
          end else begin
            we = 1'b1;
            fill_d = fill_q + 1'b1;
            total_d = 32'd1;
            full_d = 1'b0;
          end
          state_d = ips_pkg::SCAN_DONE;
        end else begin
          state_d = ips_pkg::SCAN_CHECK;
        end
      end
      ips_pkg::SCAN_CHECK: begin
        if (hit) begin
          we = 1'b1;
          wdata = {r_a, r_b, new_cnt};
          total_d = new_cnt;
          full_d = 1'b0;
          state_d = ips_pkg::SCAN_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = ips_pkg::SCAN_READ;
        end
      end
      ips_pkg::SCAN_DONE: state_d = ips_pkg::SCAN_IDLE;
      default: state_d = ips_pkg::SCAN_IDLE;
    endcase
  end

  assign sts_o.done = (state_q == ips_pkg::SCAN_DONE);
  assign sts_o.full = full_q;
  assign sts_o.total = total_q;
endmodule

// File: rtl/ipv4_packet_statistics_top.sv
// ipv4 packet statistics: class counters and source, destination, pair tables
// a non-ipv4 request goes straight to the output; an ipv4 request waits for all three table scans
// throughput: one request at a time, set by the single-port table ram scans
// reset: counters, fill counts and limits return to their reset values at once
`timescale 1ns / 1ps
module ipv4_packet_statistics_top #(
  parameter int unsigned TableEntries = ips_pkg::TableEntries
) (
  input  logic clk_i,
  input  logic rst_ni,
  ips_hdr_if.sink   hdr_i,
  ips_cfg_if.sink   cfg_i,
  ips_res_if.source res_o
);
  ips_pkg::top_state_e state_q, state_d;
  ips_pkg::hdr_t hdr_q;
  ips_pkg::res_t res_q, res_d;
  logic [15:0] lim_q [4];
  logic [31:0] proto_cnt_q [8];
  logic [31:0] size_cnt_q [5];
  logic [2:0] pc, sc;
  logic [31:0] pnew, snew;
  logic [2:0] done_q, done_d;
  ips_pkg::scan_ctl_t ctl_s, ctl_d, ctl_p;
  ips_pkg::scan_sts_t sts_s, sts_d, sts_p;
  logic accept, start;
  logic cnt_en;

  assign cfg_i.ready = 1'b1;
  assign hdr_i.ready = (state_q == ips_pkg::TOP_IDLE);
  assign accept = hdr_i.valid && hdr_i.ready;
  assign res_o.valid = (state_q == ips_pkg::TOP_OUT);
  assign res_o.data = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q[0] <= ips_pkg::LimitSmallRst;
      lim_q[1] <= ips_pkg::LimitMediumRst;
      lim_q[2] <= ips_pkg::LimitLargeRst;
      lim_q[3] <= ips_pkg::LimitHugeRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ips_pkg::REG_LIMIT_SMALL:  lim_q[0] <= cfg_i.wdata;
        ips_pkg::REG_LIMIT_MEDIUM: lim_q[1] <= cfg_i.wdata;
        ips_pkg::REG_LIMIT_LARGE:  lim_q[2] <= cfg_i.wdata;
        ips_pkg::REG_LIMIT_HUGE:   lim_q[3] <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pc = ips_pkg::proto_class(hdr_i.data.ip_protocol);
    priority if (hdr_i.data.total_length < lim_q[0]) sc = 3'd0;
    else if (hdr_i.data.total_length < lim_q[1]) sc = 3'd1;
    else if (hdr_i.data.total_length < lim_q[2]) sc = 3'd2;
    else if (hdr_i.data.total_length < lim_q[3]) sc = 3'd3;
    else sc = 3'd4;
    pnew = ips_pkg::sat_inc(proto_cnt_q[pc]);
    snew = ips_pkg::sat_inc(size_cnt_q[sc]);
  end

  assign start = accept && (hdr_i.data.ether_type == ips_pkg::EtherTypeIpv4);
  assign cnt_en = start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) proto_cnt_q[i] <= '0;
      for (int i = 0; i < 5; i++) size_cnt_q[i] <= '0;
    end else if (cnt_en) begin
      proto_cnt_q[pc] <= pnew;
      size_cnt_q[sc] <= snew;
    end
  end

  assign ctl_s = '{start: start, pair: 1'b0};
  assign ctl_d = '{start: start, pair: 1'b0};
  assign ctl_p = '{start: start, pair: 1'b1};

  ips_table #(.Entries(TableEntries)) u_src (
    .clk_i, .rst_ni, .ctl_i(ctl_s),
    .key_a_i(hdr_q.source_address), .key_b_i(32'd0), .sts_o(sts_s)
  );
  ips_table #(.Entries(TableEntries)) u_dst (
    .clk_i, .rst_ni, .ctl_i(ctl_d),
    .key_a_i(hdr_q.dest_address), .key_b_i(32'd0), .sts_o(sts_d)
  );
  ips_table #(.Entries(TableEntries)) u_pair (
    .clk_i, .rst_ni, .ctl_i(ctl_p),
    .key_a_i(hdr_q.source_address), .key_b_i(hdr_q.dest_address), .sts_o(sts_p)
  );

  always_ff @(posedge clk_i) begin
    if (accept) hdr_q <= hdr_i.data;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ips_pkg::TOP_IDLE;
      done_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d = res_q;
    done_d = done_q;
    unique case (state_q)
      ips_pkg::TOP_IDLE: begin
        if (accept) begin
          res_d = '0;
          done_d = '0;
          if (start) begin
            res_d.counted = 1'b1;
            res_d.protocol_class = pc;
            res_d.protocol_total = pnew;
            res_d.size_class = sc;
            res_d.size_total = snew;
            state_d = ips_pkg::TOP_SCAN;
          end else begin
            state_d = ips_pkg::TOP_OUT;
          end
        end
      end
      ips_pkg::TOP_SCAN: begin
        if (sts_s.done) begin
          done_d[0] = 1'b1;
          res_d.source_total = sts_s.total;
          res_d.full_flags[0] = sts_s.full;
        end
        if (sts_d.done) begin
          done_d[1] = 1'b1;
          res_d.dest_total = sts_d.total;
          res_d.full_flags[1] = sts_d.full;
        end
        if (sts_p.done) begin
          done_d[2] = 1'b1;
          res_d.pair_total = sts_p.total;
          res_d.full_flags[2] = sts_p.full;
        end
        if (done_d == 3'b111) state_d = ips_pkg::TOP_OUT;
      end
      ips_pkg::TOP_OUT: begin
        if (res_o.ready) state_d = ips_pkg::TOP_IDLE;
      end
      default: state_d = ips_pkg::TOP_IDLE;
    endcase
  end
endmodule

// File: tb/sv/ipv4_packet_statistics_tb.sv
// testbench for the ipv4 packet statistics block: scoreboard, drivers and checks
`timescale 1ns / 1ps
module testbench;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ips_hdr_if hdr ();
  ips_cfg_if cfg ();
  ips_res_if res ();

  ipv4_packet_statistics_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .hdr_i (hdr.sink),
    .cfg_i (cfg.sink),
    .res_o (res.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  class stats_scoreboard;
    logic [15:0] lim [4];
    logic [31:0] proto_cnt [8];
    logic [31:0] size_cnt [5];
    logic [31:0] src_addr [ips_pkg::TableEntries];
    logic [31:0] src_cnt [ips_pkg::TableEntries];
    logic [31:0] dst_addr [ips_pkg::TableEntries];
    logic [31:0] dst_cnt [ips_pkg::TableEntries];
    logic [31:0] pr_a [ips_pkg::TableEntries];
    logic [31:0] pr_b [ips_pkg::TableEntries];
    logic [31:0] pr_cnt [ips_pkg::TableEntries];
    ips_pkg::res_t expected_q[$];
    int errors;

    function new();
      lim[0] = ips_pkg::LimitSmallRst;
      lim[1] = ips_pkg::LimitMediumRst;
      lim[2] = ips_pkg::LimitLargeRst;
      lim[3] = ips_pkg::LimitHugeRst;
      foreach (proto_cnt[i]) proto_cnt[i] = '0;
      foreach (size_cnt[i]) size_cnt[i] = '0;
      for (int i = 0; i < ips_pkg::TableEntries; i++) begin
        src_addr[i] = '0; src_cnt[i] = '0; dst_addr[i] = '0; dst_cnt[i] = '0;
        pr_a[i] = '0; pr_b[i] = '0; pr_cnt[i] = '0;
      end
      errors = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == ips_pkg::CountMax) ? v : v + 32'd1;
    endfunction

    function void note_limit(logic [1:0] idx, logic [15:0] v);
      lim[idx] = v;
    endfunction

    function void note_header(ips_pkg::hdr_t h);
      ips_pkg::res_t r;
      logic [2:0] pc;
      logic [2:0] sc;
      bit found;
      r = '0;
      if (h.ether_type == ips_pkg::EtherTypeIpv4) begin
        case (h.ip_protocol)
          ips_pkg::ProtoIcmp: pc = ips_pkg::CLS_ICMP;
          ips_pkg::ProtoIgmp: pc = ips_pkg::CLS_IGMP;
          ips_pkg::ProtoIpip: pc = ips_pkg::CLS_IPIP;
          ips_pkg::ProtoTcp:  pc = ips_pkg::CLS_TCP;
          ips_pkg::ProtoUdp:  pc = ips_pkg::CLS_UDP;
          ips_pkg::ProtoIpv6: pc = ips_pkg::CLS_IPV6;
          ips_pkg::ProtoOspf: pc = ips_pkg::CLS_OSPF;
          default:            pc = ips_pkg::CLS_OTHER;
        endcase
        if (h.total_length < lim[0]) sc = 3'd0;
        else if (h.total_length < lim[1]) sc = 3'd1;
        else if (h.total_length < lim[2]) sc = 3'd2;
        else if (h.total_length < lim[3]) sc = 3'd3;
        else sc = 3'd4;
        proto_cnt[pc] = bump(proto_cnt[pc]);
        size_cnt[sc] = bump(size_cnt[sc]);
        r.counted = 1'b1;
        r.protocol_class = pc;
        r.protocol_total = proto_cnt[pc];
        r.size_class = sc;
        r.size_total = size_cnt[sc];
        found = 0;
        for (int i = 0; i < ips_pkg::TableEntries && !found; i++) begin
          if (src_cnt[i] == 0) begin
            src_addr[i] = h.source_address; src_cnt[i] = 1; found = 1;
            r.source_total = 1;
          end else if (src_addr[i] == h.source_address) begin
            src_cnt[i] = bump(src_cnt[i]); found = 1; r.source_total = src_cnt[i];
          end
        end
        if (!found) r.full_flags[0] = 1'b1;
        found = 0;
        for (int i = 0; i < ips_pkg::TableEntries && !found; i++) begin
          if (dst_cnt[i] == 0) begin
            dst_addr[i] = h.dest_address; dst_cnt[i] = 1; found = 1;
            r.dest_total = 1;
          end else if (dst_addr[i] == h.dest_address) begin
            dst_cnt[i] = bump(dst_cnt[i]); found = 1; r.dest_total = dst_cnt[i];
          end
        end
        if (!found) r.full_flags[1] = 1'b1;
        found = 0;
        for (int i = 0; i < ips_pkg::TableEntries && !found; i++) begin
          if (pr_cnt[i] == 0) begin
            pr_a[i] = h.source_address; pr_b[i] = h.dest_address; pr_cnt[i] = 1;
            found = 1; r.pair_total = 1;
          end else if ((pr_a[i] == h.source_address && pr_b[i] == h.dest_address) ||
                       (pr_a[i] == h.dest_address && pr_b[i] == h.source_address)) begin
            pr_cnt[i] = bump(pr_cnt[i]); found = 1; r.pair_total = pr_cnt[i];
          end
        end
        if (!found) r.full_flags[2] = 1'b1;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(ips_pkg::res_t got);
      ips_pkg::res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %h", e);
          $display("          actual   %h", got);
        end
      end
    endfunction
  endclass

  stats_scoreboard sb;
  int burst_left;
  int hold_mode;

  // receiver stall pattern
  always @(negedge clk_i) begin
    case (hold_mode)
      0: res.ready <= 1'b1;
      1: res.ready <= ($urandom_range(0, 3) != 0);
      default: res.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) sb.check_result(res.data);
  end

  task automatic send_header(ips_pkg::hdr_t h);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    burst_left--;
    hdr.valid = 1'b1;
    hdr.data = h;
    do @(posedge clk_i); while (!hdr.ready);
    sb.note_header(h);
    @(negedge clk_i);
    hdr.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (2 * ips_pkg::TableEntries + 10) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [15:0] v);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.wdata = v;
    do @(posedge clk_i); while (!cfg.ready);
    sb.note_limit(idx, v);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  task automatic set_limits(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                            logic [15:0] d);
    drain();
    write_limit(ips_pkg::REG_LIMIT_SMALL, a);
    write_limit(ips_pkg::REG_LIMIT_MEDIUM, b);
    write_limit(ips_pkg::REG_LIMIT_LARGE, c);
    write_limit(ips_pkg::REG_LIMIT_HUGE, d);
  endtask

  function automatic ips_pkg::hdr_t mk(logic [15:0] et, logic [7:0] p, logic [15:0] len,
                                       logic [31:0] s, logic [31:0] d);
    ips_pkg::hdr_t h;
    h.ether_type = et; h.ip_protocol = p; h.total_length = len;
    h.source_address = s; h.dest_address = d;
    return h;
  endfunction

  function automatic logic [7:0] pick_proto();
    logic [7:0] tbl [7];
    tbl = '{ips_pkg::ProtoIcmp, ips_pkg::ProtoIgmp, ips_pkg::ProtoIpip, ips_pkg::ProtoTcp,
            ips_pkg::ProtoUdp, ips_pkg::ProtoIpv6, ips_pkg::ProtoOspf};
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return tbl[$urandom_range(0, 6)];
  endfunction

  task automatic random_phase(int n, int pool);
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] et;
    for (int i = 0; i < n; i++) begin
      a = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0a00_0000 + $urandom_range(0, pool);
      b = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0a00_0000 + $urandom_range(0, pool);
      et = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ips_pkg::EtherTypeIpv4;
      send_header(mk(et, pick_proto(), 16'($urandom), a, b));
    end
  endtask

  initial begin
    hdr.valid = 1'b0;
    hdr.data = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.wdata = '0;
    sb = new();
    burst_left = 0;
    hold_mode = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoIcmp, 16'd0, 32'h0, 32'h0));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoIgmp, 16'd159, 32'h1, 32'h2));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoIpip, 16'd160, 32'h2, 32'h1));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoTcp, 16'd639, 32'hffff_ffff,
                   32'h0));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoUdp, 16'd640, 32'h0,
                   32'hffff_ffff));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoIpv6, 16'd1280, 32'h1, 32'h2));
    send_header(mk(ips_pkg::EtherTypeIpv4, ips_pkg::ProtoOspf, 16'd5119, 32'h5555_aaaa,
                   32'haaaa_5555));
    send_header(mk(ips_pkg::EtherTypeIpv4, 8'hff, 16'd5120, 32'haaaa_5555, 32'h5555_aaaa));
    send_header(mk(ips_pkg::EtherTypeIpv4, 8'h00, 16'hffff, 32'h1, 32'h1));
    send_header(mk(16'h0801, ips_pkg::ProtoTcp, 16'd100, 32'h1, 32'h2));
    send_header(mk(16'hffff, 8'hff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff));
    send_header(mk(16'h86dd, ips_pkg::ProtoUdp, 16'd0, 32'h0, 32'h0));
    // pause until all results are back
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    // unordered limits and extremes
    set_limits(16'd1000, 16'd10, 16'hffff, 16'd0);
    for (int i = 0; i < 8; i++)
      send_header(mk(ips_pkg::EtherTypeIpv4, pick_proto(), 16'($urandom_range(0, 2000)),
                     32'h3, 32'h4));
    hold_mode = 1;
    random_phase(120, 40);
    set_limits(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    hold_mode = 2;
    random_phase(80, 20);
    set_limits(16'd0, 16'd0, 16'd0, 16'd0);
    hold_mode = 0;
    random_phase(60, 30);
    set_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    hold_mode = 1;
    // wide addresses, mostly new entries in every table
    random_phase(40, 32'h7fff_ffff);
    set_limits(ips_pkg::LimitSmallRst, ips_pkg::LimitMediumRst, ips_pkg::LimitLargeRst,
               ips_pkg::LimitHugeRst);
    random_phase(110, 100);
    hold_mode = 0;
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

// File: files.f
rtl/ips_pkg.sv
rtl/ips_if.sv
rtl/ips_ram.sv
rtl/ips_table.sv
rtl/ipv4_packet_statistics_top.sv
tb/sv/ipv4_packet_statistics_tb.sv
